// File: rtl/lateral_steering_controller_assert.svh
// Assertion macros for the lateral steering controller.
// Used by the top level only; expects clk and rst in scope.
`ifndef LATERAL_STEERING_CONTROLLER_ASSERT_SVH
`define LATERAL_STEERING_CONTROLLER_ASSERT_SVH
`ifndef ASSERT_OFF
`define LSC_ASSERT_HOLD(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("lsc assertion failed");
`define LSC_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("lsc assertion failed");
`define LSC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("lsc assertion failed");
`else
`define LSC_ASSERT_HOLD(label, expr)
`define LSC_ASSERT_IMPL(label, pre, post)
`define LSC_ASSERT_NEXT(label, pre, post)
`endif
`endif

// File: rtl/lsc_pkg.sv
// Shared types, constants and sequencing functions of the steering controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package lsc_pkg;

  localparam int ACC_W        = 64;  // datapath word
  localparam int MUL_B_W      = 18;  // narrow multiplier operand, signed
  localparam int ANG_W        = 20;  // Q.16 angle
  localparam int CS_W         = 18;  // Q.16 cos / sin
  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_IN_W    = 34;
  localparam int SQRT_OUT_W   = 17;
  localparam int SQRT_STEPS   = 17;
  localparam int LA_W         = 18;

  localparam int FAI_LIMIT    = 6434;
  localparam int LD_DEFAULT   = 512;
  localparam int WIND_LIMIT   = 25600;
  localparam int CORDIC_K     = 39797;
  localparam int PI_Q16       = 205887;
  localparam int HALF_PI_Q16  = 102944;
  localparam int PD_X_SHIFT   = 28;

  typedef enum logic [1:0] {
    MODE_PID      = 2'd0,
    MODE_PURSUIT  = 2'd1,
    MODE_COS_PD   = 2'd2,
    MODE_PURSUIT3 = 2'd3
  } lsc_mode_t;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_WHEELBASE = 3'd1,
    REG_PID_P     = 3'd2,
    REG_PID_I     = 3'd3,
    REG_PID_D     = 3'd4,
    REG_TRK_I     = 3'd5,
    REG_PD_OFF    = 3'd6,
    REG_PD_HEAD   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    lsc_mode_t   mode;
    logic [15:0] wheelbase;
    logic [15:0] pid_p_gain;
    logic [15:0] pid_i_gain;
    logic [15:0] pid_d_gain;
    logic [15:0] track_integral_gain;
    logic [15:0] pd_offset_gain;
    logic [15:0] pd_heading_gain;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_PID_SUM, OP_M_PD, OP_M_IS, OP_M_DD, OP_PID_FIN,
    OP_LA_UPD, OP_M_LL, OP_M_D2, OP_SQRT, OP_SINCOS,
    OP_M_DC, OP_M_RS, OP_M_Y1, OP_ATAN_PP,
    OP_M_CC, OP_M_C3, OP_M_KD, OP_M_PA, OP_M_SC, OP_M_PB, OP_M_Y2, OP_ATAN_PD,
    OP_INTEG, OP_M_IT, OP_TRK_FIN
  } op_t;

  typedef enum logic [1:0] {
    UNIT_NONE,
    UNIT_MUL,
    UNIT_CORDIC,
    UNIT_SQRT
  } unit_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic emit;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic done;
  } status_t;

  function automatic logic [15:0] atan_entry(input logic [3:0] i);
    logic [15:0] v;
    case (i)
      4'd0:    v = 16'd51472;
      4'd1:    v = 16'd30386;
      4'd2:    v = 16'd16055;
      4'd3:    v = 16'd8150;
      4'd4:    v = 16'd4091;
      4'd5:    v = 16'd2047;
      4'd6:    v = 16'd1024;
      4'd7:    v = 16'd512;
      4'd8:    v = 16'd256;
      4'd9:    v = 16'd128;
      4'd10:   v = 16'd64;
      4'd11:   v = 16'd32;
      4'd12:   v = 16'd16;
      4'd13:   v = 16'd8;
      4'd14:   v = 16'd4;
      default: v = 16'd2;
    endcase
    return v;
  endfunction

  function automatic unit_t op_unit(input op_t op);
    unit_t u;
    case (op)
      OP_PID_SUM, OP_PID_FIN, OP_LA_UPD, OP_INTEG, OP_TRK_FIN: u = UNIT_NONE;
      OP_SINCOS, OP_ATAN_PP, OP_ATAN_PD:                       u = UNIT_CORDIC;
      OP_SQRT:                                                 u = UNIT_SQRT;
      default:                                                 u = UNIT_MUL;
    endcase
    return u;
  endfunction

  function automatic logic op_is_final(input op_t op);
    return (op == OP_PID_FIN) || (op == OP_TRK_FIN);
  endfunction

  function automatic op_t first_op(input lsc_mode_t mode);
    op_t o;
    case (mode)
      MODE_PID:    o = OP_PID_SUM;
      MODE_COS_PD: o = OP_SINCOS;
      default:     o = OP_LA_UPD;
    endcase
    return o;
  endfunction

  function automatic op_t next_op(input lsc_mode_t mode, input op_t op);
    op_t o;
    case (op)
      OP_PID_SUM: o = OP_M_PD;
      OP_M_PD:    o = OP_M_IS;
      OP_M_IS:    o = OP_M_DD;
      OP_M_DD:    o = OP_PID_FIN;
      OP_LA_UPD:  o = OP_M_LL;
      OP_M_LL:    o = OP_M_D2;
      OP_M_D2:    o = OP_SQRT;
      OP_SQRT:    o = OP_SINCOS;
      OP_SINCOS:  o = (mode == MODE_COS_PD) ? OP_M_CC : OP_M_DC;
      OP_M_DC:    o = OP_M_RS;
      OP_M_RS:    o = OP_M_Y1;
      OP_M_Y1:    o = OP_ATAN_PP;
      OP_ATAN_PP: o = OP_INTEG;
      OP_M_CC:    o = OP_M_C3;
      OP_M_C3:    o = OP_M_KD;
      OP_M_KD:    o = OP_M_PA;
      OP_M_PA:    o = OP_M_SC;
      OP_M_SC:    o = OP_M_PB;
      OP_M_PB:    o = OP_M_Y2;
      OP_M_Y2:    o = OP_ATAN_PD;
      OP_ATAN_PD: o = OP_INTEG;
      OP_INTEG:   o = OP_M_IT;
      OP_M_IT:    o = OP_TRK_FIN;
      default:    o = OP_TRK_FIN;
    endcase
    return o;
  endfunction

endpackage

// File: rtl/lsc_mul.sv
// Serial shift-add multiplier: wide signed operand times 18-bit signed operand.
// One partial product per cycle; depends on lsc_pkg.
`timescale 1ns / 1ps
module lsc_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [lsc_pkg::ACC_W-1:0]    a,
  input  logic signed [lsc_pkg::MUL_B_W-1:0]  b,
  output logic                                done,
  output logic signed [lsc_pkg::ACC_W-1:0]    prod
);
  import lsc_pkg::*;

  localparam int CNT_W = $clog2(MUL_B_W);

  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  logic signed [ACC_W-1:0] ma;
  logic [MUL_B_W-1:0]      mb;
  logic signed [ACC_W-1:0] acc;
  logic                    last_bit;

  assign last_bit = (cnt == CNT_W'(MUL_B_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last_bit) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // top bit of b carries negative weight
  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= a;
      mb  <= b;
      acc <= '0;
    end else if (busy) begin
      if (mb[0]) begin
        acc <= last_bit ? acc - ma : acc + ma;
      end
      ma <= ma <<< 1;
      mb <= mb >> 1;
    end
  end

  assign prod = acc;

endmodule

// File: rtl/lsc_cordic.sv
// Shared 16-step CORDIC: rotation gives cos/sin, vectoring gives atan2 (x > 0).
// Depends on lsc_pkg for widths and the arctangent table.
`timescale 1ns / 1ps
module lsc_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              vec,
  input  logic signed [lsc_pkg::ACC_W-1:0]  x_in,
  input  logic signed [lsc_pkg::ACC_W-1:0]  y_in,
  input  logic signed [lsc_pkg::ANG_W-1:0]  z_in,
  output logic                              done,
  output logic signed [lsc_pkg::ACC_W-1:0]  x_out,
  output logic signed [lsc_pkg::ACC_W-1:0]  y_out,
  output logic signed [lsc_pkg::ANG_W-1:0]  z_out
);
  import lsc_pkg::*;

  localparam int CNT_W = $clog2(CORDIC_STEPS);

  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  logic signed [ACC_W-1:0] x, y, dx, dy;
  logic signed [ANG_W-1:0] z, tab;
  logic                    vec_r, flip, neg, zero, pos;

  assign dx  = y >>> cnt;
  assign dy  = x >>> cnt;
  assign tab = {{(ANG_W-16){1'b0}}, atan_entry(cnt)};
  assign pos = vec_r ? (y <= 0) : (z >= 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      vec_r <= vec;
      x     <= x_in;
      if (vec) begin
        neg  <= (y_in < 0);
        zero <= (y_in == 0);
        y    <= (y_in < 0) ? -y_in : y_in;
        z    <= z_in;
        flip <= 1'b0;
      end else begin
        neg  <= 1'b0;
        zero <= 1'b0;
        y    <= y_in;
        // fold into +-pi/2, flip signs of the result
        if (z_in > ANG_W'(HALF_PI_Q16)) begin
          z    <= z_in - ANG_W'(PI_Q16);
          flip <= 1'b1;
        end else if (z_in < ANG_W'(-HALF_PI_Q16)) begin
          z    <= z_in + ANG_W'(PI_Q16);
          flip <= 1'b1;
        end else begin
          z    <= z_in;
          flip <= 1'b0;
        end
      end
    end else if (busy) begin
      if (pos) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - tab;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + tab;
      end
    end
  end

  assign x_out = flip ? -x : x;
  assign y_out = flip ? -y : y;
  assign z_out = zero ? '0 : (neg ? -z : z);

endmodule

// File: rtl/lsc_isqrt.sv
// Floor square root, one result bit per cycle (digit-by-digit).
// Depends on lsc_pkg for widths.
`timescale 1ns / 1ps
module lsc_isqrt (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [lsc_pkg::SQRT_IN_W-1:0]      v_in,
  output logic                               done,
  output logic [lsc_pkg::SQRT_OUT_W-1:0]     root
);
  import lsc_pkg::*;

  localparam int CNT_W = $clog2(SQRT_STEPS);
  localparam logic [SQRT_IN_W-1:0] BIT_INIT = SQRT_IN_W'(1) << (2 * (SQRT_STEPS - 1));

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [SQRT_IN_W-1:0] v, bm;
  logic [SQRT_IN_W:0]   r, trial;

  assign trial = r + {1'b0, bm};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v  <= v_in;
      r  <= '0;
      bm <= BIT_INIT;
    end else if (busy) begin
      if ({1'b0, v} >= trial) begin
        v <= v - trial[SQRT_IN_W-1:0];
        r <= (r >> 1) + {1'b0, bm};
      end else begin
        r <= r >> 1;
      end
      bm <= bm >> 2;
    end
  end

  assign root = r[SQRT_OUT_W-1:0];

endmodule

// File: rtl/lsc_dp.sv
// Datapath: operand registers, loop state, and the shared arithmetic units.
// Depends on lsc_pkg, lsc_mul, lsc_cordic and lsc_isqrt.
`timescale 1ns / 1ps
module lsc_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  lsc_pkg::cfg_t        cfg,
  input  lsc_pkg::cmd_t        cmd,
  input  logic signed [15:0]   lateral_offset,
  input  logic signed [15:0]   heading_error,
  output lsc_pkg::status_t     status,
  output logic signed [15:0]   steer_angle,
  output logic                 saturated
);
  import lsc_pkg::*;

  // loop state
  logic signed [39:0]      pid_error_sum;
  logic signed [15:0]      pid_last_error;
  logic signed [23:0]      offset_integral;
  logic [LA_W-1:0]         lookahead;

  // item operands and intermediates
  logic signed [15:0]      d_reg;
  logic signed [ANG_W-1:0] h_reg, ang_reg;
  logic signed [CS_W-1:0]  c_reg, s_reg, c2_reg, c3_reg;
  logic signed [ACC_W-1:0] t_reg, pa_reg, acc_reg;
  logic [SQRT_IN_W-1:0]    ld2_reg;
  logic [SQRT_OUT_W-1:0]   root_reg;

  // units
  logic                     mul_start, mul_done;
  logic signed [ACC_W-1:0]  mul_a, mul_prod;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                     cor_start, cor_done, cor_vec;
  logic signed [ACC_W-1:0]  cor_x, cor_y, cor_xo, cor_yo;
  logic signed [ANG_W-1:0]  cor_z, cor_zo;
  logic                     sq_start, sq_done;
  logic [SQRT_IN_W-1:0]     sq_in;
  logic [SQRT_OUT_W-1:0]    sq_root;

  // combinational helpers
  logic signed [40:0]       sum_ext;
  logic signed [24:0]       oi_ext;
  logic                     oi_hold;
  logic [15:0]              abs_d;
  logic signed [ACC_W-1:0]  rad, pd_diff, prod_sh16, prod_sh8, pid_v, trk_v;
  logic signed [ACC_W-1:0]  ld2_wide;

  assign mul_start = cmd.start && (op_unit(cmd.op) == UNIT_MUL);
  assign cor_start = cmd.start && (op_unit(cmd.op) == UNIT_CORDIC);
  assign sq_start  = cmd.start && (op_unit(cmd.op) == UNIT_SQRT);

  assign pd_diff   = (pa_reg - t_reg) >>> 16;
  assign prod_sh16 = mul_prod >>> 16;
  assign prod_sh8  = mul_prod >>> 8;
  assign ld2_wide  = {{(ACC_W-SQRT_IN_W){1'b0}}, ld2_reg};
  assign rad       = ld2_wide - t_reg;
  assign sq_in     = (rad > 0) ? rad[SQRT_IN_W-1:0] : '0;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_M_PD: begin
        mul_a = {{(ACC_W-16){1'b0}}, cfg.pid_p_gain};
        mul_b = MUL_B_W'(d_reg);
      end
      OP_M_IS: begin
        mul_a = ACC_W'(pid_error_sum);
        mul_b = {{(MUL_B_W-16){1'b0}}, cfg.pid_i_gain};
      end
      OP_M_DD: begin
        mul_a = {{(ACC_W-16){1'b0}}, cfg.pid_d_gain};
        mul_b = MUL_B_W'(d_reg) - MUL_B_W'(pid_last_error);
      end
      OP_M_CC: begin
        mul_a = ACC_W'(c_reg);
        mul_b = MUL_B_W'(c_reg);
      end
      OP_M_C3: begin
        mul_a = ACC_W'(c2_reg);
        mul_b = MUL_B_W'(c_reg);
      end
      OP_M_KD: begin
        mul_a = {{(ACC_W-16){1'b0}}, cfg.pd_offset_gain};
        mul_b = MUL_B_W'(d_reg);
      end
      OP_M_PA: begin
        mul_a = t_reg;
        mul_b = MUL_B_W'(c3_reg);
      end
      OP_M_SC: begin
        mul_a = ACC_W'(c2_reg);
        mul_b = MUL_B_W'(s_reg);
      end
      OP_M_PB: begin
        mul_a = t_reg;
        mul_b = {{(MUL_B_W-16){1'b0}}, cfg.pd_heading_gain};
      end
      OP_M_Y2: begin
        mul_a = pd_diff;
        mul_b = {{(MUL_B_W-16){1'b0}}, cfg.wheelbase};
      end
      OP_M_LL: begin
        mul_a = {{(ACC_W-LA_W){1'b0}}, lookahead};
        mul_b = lookahead;
      end
      OP_M_D2: begin
        mul_a = ACC_W'(d_reg);
        mul_b = MUL_B_W'(d_reg);
      end
      OP_M_DC: begin
        mul_a = ACC_W'(d_reg);
        mul_b = MUL_B_W'(c_reg);
      end
      OP_M_RS: begin
        mul_a = {{(ACC_W-SQRT_OUT_W){1'b0}}, root_reg};
        mul_b = MUL_B_W'(s_reg);
      end
      OP_M_Y1: begin
        mul_a = t_reg;
        mul_b = {{(MUL_B_W-16){1'b0}}, cfg.wheelbase};
      end
      OP_M_IT: begin
        mul_a = ACC_W'(offset_integral);
        mul_b = {{(MUL_B_W-16){1'b0}}, cfg.track_integral_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    cor_vec = 1'b0;
    cor_x   = ACC_W'(CORDIC_K);
    cor_y   = '0;
    cor_z   = h_reg;
    case (cmd.op)
      OP_ATAN_PP: begin
        cor_vec = 1'b1;
        cor_x   = ld2_wide <<< 16;
        cor_y   = t_reg;
        cor_z   = '0;
      end
      OP_ATAN_PD: begin
        cor_vec = 1'b1;
        cor_x   = ACC_W'(1) <<< PD_X_SHIFT;
        cor_y   = t_reg;
        cor_z   = '0;
      end
      default: begin
        cor_vec = 1'b0;
      end
    endcase
  end

  lsc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  lsc_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .vec   (cor_vec),
    .x_in  (cor_x),
    .y_in  (cor_y),
    .z_in  (cor_z),
    .done  (cor_done),
    .x_out (cor_xo),
    .y_out (cor_yo),
    .z_out (cor_zo)
  );

  lsc_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .v_in  (sq_in),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign status.done = mul_done | cor_done | sq_done;

  // combinational arithmetic
  assign sum_ext = 41'(pid_error_sum) + 41'(d_reg);
  assign oi_ext  = 25'(offset_integral) + 25'(d_reg);
  assign oi_hold = ((offset_integral > 24'(WIND_LIMIT)) && (d_reg > 16'sd0)) ||
                   ((offset_integral < 24'(-WIND_LIMIT)) && (d_reg < 16'sd0));
  assign abs_d   = d_reg[15] ? 16'(-d_reg) : d_reg;
  assign pid_v   = (acc_reg + ACC_W'(64)) >>> 7;
  assign trk_v   = ((ACC_W'(ang_reg) <<< 4) + acc_reg + ACC_W'(64)) >>> 7;

  // loop state; reset clears the sums and last error and loads the default lookahead
  always_ff @(posedge clk) begin
    if (rst) begin
      pid_error_sum   <= '0;
      pid_last_error  <= '0;
      offset_integral <= '0;
      lookahead       <= LA_W'(LD_DEFAULT);
    end else begin
      if (cmd.start && cmd.op == OP_PID_SUM) begin
        if (sum_ext[40] != sum_ext[39]) begin
          pid_error_sum <= sum_ext[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        end else begin
          pid_error_sum <= sum_ext[39:0];
        end
      end
      if (mul_done && cmd.op == OP_M_DD) begin
        pid_last_error <= d_reg;
      end
      if (cmd.start && cmd.op == OP_INTEG && !oi_hold) begin
        if (oi_ext[24] != oi_ext[23]) begin
          offset_integral <= oi_ext[24] ? {1'b1, 23'd0} : {1'b0, {23{1'b1}}};
        end else begin
          offset_integral <= oi_ext[23:0];
        end
      end
      if (cmd.start && cmd.op == OP_LA_UPD) begin
        if ({2'b00, abs_d} >= lookahead) begin
          lookahead <= ({2'b00, abs_d} << 1) + {2'b00, abs_d};
        end else begin
          lookahead <= LA_W'(LD_DEFAULT);
        end
      end
    end
  end

  // per-item operands and results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d_reg <= lateral_offset;
      h_reg <= ANG_W'(heading_error) <<< 3;
    end
    if (mul_done) begin
      case (cmd.op)
        OP_M_PD: acc_reg <= mul_prod;
        OP_M_IS: acc_reg <= acc_reg + mul_prod;
        OP_M_DD: acc_reg <= acc_reg + mul_prod;
        OP_M_CC: c2_reg  <= prod_sh16[CS_W-1:0];
        OP_M_C3: c3_reg  <= prod_sh16[CS_W-1:0];
        OP_M_KD: t_reg   <= mul_prod;
        OP_M_PA: pa_reg  <= mul_prod;
        OP_M_SC: t_reg   <= mul_prod;
        OP_M_PB: t_reg   <= prod_sh8;
        OP_M_Y2: t_reg   <= mul_prod;
        OP_M_LL: ld2_reg <= mul_prod[SQRT_IN_W-1:0];
        OP_M_D2: t_reg   <= mul_prod;
        OP_M_DC: t_reg   <= mul_prod;
        OP_M_RS: t_reg   <= mul_prod - t_reg;   // inner = root*s - d*c
        OP_M_Y1: t_reg   <= -(mul_prod <<< 1);
        OP_M_IT: acc_reg <= mul_prod;
        default: acc_reg <= acc_reg;
      endcase
    end
    if (cor_done) begin
      if (cmd.op == OP_SINCOS) begin
        c_reg <= cor_xo[CS_W-1:0];
        s_reg <= cor_yo[CS_W-1:0];
      end else begin
        ang_reg <= cor_zo;
      end
    end
    if (sq_done) begin
      root_reg <= sq_root;
    end
    if (cmd.start && cmd.op == OP_PID_FIN) begin
      if (pid_v > ACC_W'(32767)) begin
        steer_angle <= 16'sh7fff;
        saturated   <= 1'b1;
      end else if (pid_v < ACC_W'(-32768)) begin
        steer_angle <= 16'sh8000;
        saturated   <= 1'b1;
      end else begin
        steer_angle <= pid_v[15:0];
        saturated   <= 1'b0;
      end
    end
    if (cmd.start && cmd.op == OP_TRK_FIN) begin
      if (cfg.mode == MODE_COS_PD) begin
        if (trk_v > ACC_W'(32767)) begin
          steer_angle <= 16'sh7fff;
          saturated   <= 1'b1;
        end else if (trk_v < ACC_W'(-32768)) begin
          steer_angle <= 16'sh8000;
          saturated   <= 1'b1;
        end else begin
          steer_angle <= trk_v[15:0];
          saturated   <= 1'b0;
        end
      end else begin
        if (trk_v > ACC_W'(FAI_LIMIT)) begin
          steer_angle <= 16'(FAI_LIMIT);
          saturated   <= 1'b1;
        end else if (trk_v < ACC_W'(-FAI_LIMIT)) begin
          steer_angle <= 16'(-FAI_LIMIT);
          saturated   <= 1'b1;
        end else begin
          steer_angle <= trk_v[15:0];
          saturated   <= 1'b0;
        end
      end
    end
  end

endmodule

// File: rtl/lsc_ctrl.sv
// Controller: steps through the operation sequence of the selected control law.
// Depends on lsc_pkg for the op codes and sequencing functions.
`timescale 1ns / 1ps
module lsc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  lsc_pkg::lsc_mode_t mode,
  input  logic               in_valid,
  input  logic               out_free,
  input  lsc_pkg::status_t   status,
  output logic               in_ready,
  output lsc_pkg::cmd_t      cmd
);
  import lsc_pkg::*;

  ctrl_state_t state, state_next;
  op_t         op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_PID_SUM;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.start  = 1'b0;
    cmd.emit   = 1'b0;
    cmd.op     = op;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          op_next    = first_op(mode);
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (op_is_final(op)) begin
          // result register must be free before it is overwritten
          if (out_free) begin
            cmd.start  = 1'b1;
            cmd.emit   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.start = 1'b1;
          if (op_unit(op) == UNIT_NONE) begin
            op_next = next_op(mode, op);
          end else begin
            state_next = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (status.done) begin
          op_next    = next_op(mode, op);
          state_next = ST_ISSUE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/lateral_steering_controller.sv
// Lateral steering controller: PID, pure pursuit or cosine PD law per item.
// The serial multiplier is shared by every product. One item at a time: the next item is taken
// the cycle after the result is loaded, even while the result register waits.
// Synchronous reset loads register defaults and clears the loop state (no clearing pass).
`timescale 1ns / 1ps
`include "lateral_steering_controller_assert.svh"
module lateral_steering_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] lateral_offset, [31:16] heading_error
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [15:0] steer_angle, [16] saturated, rest zero
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import lsc_pkg::*;

  cfg_t               cfg;
  cmd_t               cmd;
  status_t            status;
  logic               out_free;
  logic signed [15:0] steer_angle;
  logic               saturated;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode                <= MODE_PURSUIT;
      cfg.wheelbase           <= 16'd640;
      cfg.pid_p_gain          <= 16'd819;
      cfg.pid_i_gain          <= 16'd41;
      cfg.pid_d_gain          <= 16'd4915;
      cfg.track_integral_gain <= 16'd0;
      cfg.pd_offset_gain      <= 16'd1044;
      cfg.pd_heading_gain     <= 16'd4096;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MODE:      cfg.mode                <= lsc_mode_t'(cfg_data[1:0]);
        REG_WHEELBASE: cfg.wheelbase           <= cfg_data;
        REG_PID_P:     cfg.pid_p_gain          <= cfg_data;
        REG_PID_I:     cfg.pid_i_gain          <= cfg_data;
        REG_PID_D:     cfg.pid_d_gain          <= cfg_data;
        REG_TRK_I:     cfg.track_integral_gain <= cfg_data;
        REG_PD_OFF:    cfg.pd_offset_gain      <= cfg_data;
        REG_PD_HEAD:   cfg.pd_heading_gain     <= cfg_data;
        default:       cfg.mode                <= cfg.mode;
      endcase
    end
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  lsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .mode     (cfg.mode),
    .in_valid (s_tvalid),
    .out_free (out_free),
    .status   (status),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  lsc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .lateral_offset (s_tdata[15:0]),
    .heading_error  (s_tdata[31:16]),
    .status         (status),
    .steer_angle    (steer_angle),
    .saturated      (saturated)
  );

  assign m_tdata = {7'd0, saturated, steer_angle};

  `LSC_ASSERT_IMPL(a_emit_slot_free, cmd.emit, out_free)
  `LSC_ASSERT_NEXT(a_emit_sets_valid, cmd.emit, m_tvalid)
  `LSC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `LSC_ASSERT_IMPL(a_valid_from_emit, $rose(m_tvalid), $past(cmd.emit))

endmodule
